// ----- hdl/erx_pkg.sv -----
// ----------------------------------------------------------------------------
// erx_pkg: shared definitions for the escaped frame receiver
// Holds the line byte codes, verdict codes, frame error codes and the result
// record that travels from the deframer to the output queue.
// ----------------------------------------------------------------------------
package erx_pkg;

   localparam int FRAME_MAX_DEFAULT = 256;

   // line byte codes
   localparam logic [7:0] BYTE_HEADER  = 8'hFF;
   localparam logic [7:0] BYTE_TRAILER = 8'hFE;
   localparam logic [7:0] BYTE_ESCAPE  = 8'hFD;
   localparam logic [7:0] ESC_CODE_FF  = 8'h00;
   localparam logic [7:0] ESC_CODE_FE  = 8'h01;
   localparam logic [7:0] ESC_CODE_FD  = 8'h02;

   // frame layout
   localparam int POS_RETURN   = 9;
   localparam int POS_COMMAND  = 10;
   localparam int POS_LENGTH   = 11;
   localparam int POS_PAYLOAD  = 12;

   // verdict codes
   localparam logic [2:0] VERDICT_GOOD     = 3'd0;
   localparam logic [2:0] VERDICT_ESCAPE   = 3'd1;
   localparam logic [2:0] VERDICT_SHORT    = 3'd2;
   localparam logic [2:0] VERDICT_CHECKSUM = 3'd3;
   localparam logic [2:0] VERDICT_RETURN   = 3'd4;
   localparam logic [2:0] VERDICT_COMMAND  = 3'd5;
   localparam logic [2:0] VERDICT_OVERFLOW = 3'd6;
   localparam logic [2:0] VERDICT_ABORTED  = 3'd7;

   // sticky frame error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_ESCAPE   = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd2;

   localparam logic ITEM_PAYLOAD = 1'b0;
   localparam logic ITEM_VERDICT = 1'b1;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] payload_byte;
      logic [2:0] verdict;
      logic       frame_last;
   } res_type;

endpackage

// ----- hdl/escaped_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// escaped_frame_receiver: byte-stuffed frame deframer with XOR checksum
// Path: an accepted req beat is held in the input register, decoded by the deframer and written to the result queue.
// Throughput: one req beat per cycle while the result queue has room; the deframer decode
// between the input register and the two-entry result queue is combinational.
// Reset: synchronous, active high; hunts for a header, expected_command is 0.
// ----------------------------------------------------------------------------
module escaped_frame_receiver
   import erx_pkg::*;
#(
   parameter int MAX_FRAME = FRAME_MAX_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // received line bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // payload and verdict beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] payload_byte, [10:8] verdict, [15:11] zero
   output logic        rsp_tuser,   // [0] item_kind
   output logic        rsp_tlast,   // frame_last
   // command register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // [7:0] expected_command
);

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic [7:0] cmd_ff;

   logic       advance;
   logic       q_full;
   logic       res_valid;
   res_type    res_data;
   res_type    rsp_item;

   // Advance the held byte whenever the queue has a free slot; the byte may
   // yield no result, one payload byte, or one verdict.
   assign advance    = in_vld_ff && !q_full;
   assign req_tready = !in_vld_ff || !q_full;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         cmd_ff    <= 8'h00;
      end else begin
         in_vld_ff <= in_vld_in;
         if (csr_valid && csr_ready) begin
            cmd_ff <= csr_data;
         end
      end
   end

   erx_deframer #(
      .MAX_FRAME (MAX_FRAME)
   ) u_deframer (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (advance),
      .in_byte          (in_byte_ff),
      .expected_command (cmd_ff),
      .res_valid        (res_valid),
      .res_data         (res_data)
   );

   erx_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_item),
      .full      (q_full)
   );

   // pack the result beat
   assign rsp_tdata = {5'b0, rsp_item.verdict, rsp_item.payload_byte};
   assign rsp_tuser = rsp_item.item_kind;
   assign rsp_tlast = rsp_item.frame_last;

   // verdict beats always close a frame, payload beats never do
   a_last_matches_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == rsp_tuser))
      else $error("tlast does not match item kind");

   // payload beats carry a zero verdict
   a_payload_verdict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata[10:8] == VERDICT_GOOD))
      else $error("payload beat with nonzero verdict");

   // the input side stalls only when a byte waits on a full queue
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_vld_ff && q_full && rsp_tvalid))
      else $error("input stalled without a full result queue");

   // a held byte with room in the queue is consumed next cycle unless replaced
   a_held_byte_moves: assert property (@(posedge clock) disable iff (reset)
      advance && !req_tvalid |=> !in_vld_ff)
      else $error("held byte not consumed");

endmodule

// ----- hdl/erx_deframer.sv -----
// ----------------------------------------------------------------------------
// erx_deframer: frame state and per-byte decode
// Hunts for the header, removes escapes, tracks position, checksum and header
// fields, and produces at most one result per byte.
// ----------------------------------------------------------------------------
module erx_deframer
   import erx_pkg::*;
#(
   parameter int MAX_FRAME = FRAME_MAX_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic [7:0] in_byte,
   input  logic [7:0] expected_command,
   output logic       res_valid,
   output res_type    res_data
);

   localparam int POS_W = $clog2(MAX_FRAME);
   localparam int CMP_W = 10;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_FRAME - 1);

   logic             in_frame_ff,  in_frame_in;
   logic             esc_ff,       esc_in;
   logic [POS_W-1:0] pos_ff,       pos_in;
   logic [7:0]       xor_ff,       xor_in;
   logic [7:0]       held_ff,      held_in;
   logic             held_vld_ff,  held_vld_in;
   logic [7:0]       len_ff,       len_in;
   logic             ret_bad_ff,   ret_bad_in;
   logic             cmd_bad_ff,   cmd_bad_in;
   logic [1:0]       err_ff,       err_in;

   logic             take;
   logic [7:0]       take_byte;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] held_pos;
   logic [CMP_W-1:0] payload_end;
   logic [CMP_W-1:0] payload_end_cur;
   logic [2:0]       judged;

   assign pos_ext         = CMP_W'(pos_ff);
   assign held_pos        = pos_ext - CMP_W'(1);
   assign payload_end_cur = CMP_W'(POS_PAYLOAD) + CMP_W'(len_ff);

   always_comb begin
      if (esc_ff || err_ff == ERR_ESCAPE) begin
         judged = VERDICT_ESCAPE;
      end else if (err_ff == ERR_OVERFLOW) begin
         judged = VERDICT_OVERFLOW;
      end else if (!held_vld_ff || held_pos < payload_end_cur) begin
         judged = VERDICT_SHORT;
      end else if (xor_ff != held_ff) begin
         judged = VERDICT_CHECKSUM;
      end else if (ret_bad_ff) begin
         judged = VERDICT_RETURN;
      end else if (cmd_bad_ff) begin
         judged = VERDICT_COMMAND;
      end else begin
         judged = VERDICT_GOOD;
      end
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      esc_in      = esc_ff;
      pos_in      = pos_ff;
      xor_in      = xor_ff;
      held_in     = held_ff;
      held_vld_in = held_vld_ff;
      len_in      = len_ff;
      ret_bad_in  = ret_bad_ff;
      cmd_bad_in  = cmd_bad_ff;
      err_in      = err_ff;
      res_valid   = 1'b0;
      res_data    = '0;
      take        = 1'b0;
      take_byte   = in_byte;
      payload_end = payload_end_cur;

      if (in_valid) begin
         if (in_byte == BYTE_HEADER || (in_frame_ff && in_byte == BYTE_TRAILER)) begin
            if (in_byte == BYTE_HEADER) begin
               res_valid = in_frame_ff;
               res_data  = '{ITEM_VERDICT, 8'h00, VERDICT_ABORTED, 1'b1};
            end else begin
               res_valid = 1'b1;
               res_data  = '{ITEM_VERDICT, 8'h00, judged, 1'b1};
            end
            in_frame_in = (in_byte == BYTE_HEADER);
            esc_in      = 1'b0;
            pos_in      = (in_byte == BYTE_HEADER) ? POS_W'(1) : '0;
            xor_in      = '0;
            held_in     = '0;
            held_vld_in = 1'b0;
            len_in      = '0;
            ret_bad_in  = 1'b0;
            cmd_bad_in  = 1'b0;
            err_in      = ERR_NONE;
         end else if (in_frame_ff && err_ff == ERR_NONE) begin
            if (esc_ff) begin
               esc_in = 1'b0;
               unique case (in_byte)
                  ESC_CODE_FF: begin take = 1'b1; take_byte = BYTE_HEADER;  end
                  ESC_CODE_FE: begin take = 1'b1; take_byte = BYTE_TRAILER; end
                  ESC_CODE_FD: begin take = 1'b1; take_byte = BYTE_ESCAPE;  end
                  default:     err_in = ERR_ESCAPE;
               endcase
            end else if (in_byte == BYTE_ESCAPE) begin
               esc_in = 1'b1;
            end else begin
               take = 1'b1;
            end

            if (take) begin
               if (pos_ff >= POS_LIMIT) begin
                  err_in = ERR_OVERFLOW;
               end else begin
                  if (pos_ext == CMP_W'(POS_RETURN) && take_byte != 8'h00) begin
                     ret_bad_in = 1'b1;
                  end
                  if (pos_ext == CMP_W'(POS_COMMAND) && take_byte != expected_command) begin
                     cmd_bad_in = 1'b1;
                  end
                  if (pos_ext == CMP_W'(POS_LENGTH)) begin
                     len_in = take_byte;
                  end
                  payload_end = CMP_W'(POS_PAYLOAD) + CMP_W'(len_in);
                  if (held_vld_ff) begin
                     xor_in = xor_ff ^ held_ff;
                     if (held_pos >= CMP_W'(POS_PAYLOAD) && held_pos < payload_end) begin
                        res_valid = 1'b1;
                        res_data  = '{ITEM_PAYLOAD, held_ff, VERDICT_GOOD, 1'b0};
                     end
                  end
                  held_in     = take_byte;
                  held_vld_in = 1'b1;
                  pos_in      = pos_ff + POS_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         esc_ff      <= 1'b0;
         pos_ff      <= '0;
         xor_ff      <= '0;
         held_ff     <= '0;
         held_vld_ff <= 1'b0;
         len_ff      <= '0;
         ret_bad_ff  <= 1'b0;
         cmd_bad_ff  <= 1'b0;
         err_ff      <= ERR_NONE;
      end else begin
         in_frame_ff <= in_frame_in;
         esc_ff      <= esc_in;
         pos_ff      <= pos_in;
         xor_ff      <= xor_in;
         held_ff     <= held_in;
         held_vld_ff <= held_vld_in;
         len_ff      <= len_in;
         ret_bad_ff  <= ret_bad_in;
         cmd_bad_ff  <= cmd_bad_in;
         err_ff      <= err_in;
      end
   end

endmodule

// ----- hdl/erx_out_queue.sv -----
// ----------------------------------------------------------------------------
// erx_out_queue: two-entry result queue
// Two slots with read and write pointers; full comes from the registered count so the result side never
// reaches back into the input handshake.
// ----------------------------------------------------------------------------
module erx_out_queue
   import erx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  res_type push_data,
   output logic    out_valid,
   input  logic    out_ready,
   output res_type out_data,
   output logic    full
);

   res_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign full      = (count_ff == 2'd2);
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- dv/escaped_frame_receiver_test.sv -----
// ----------------------------------------------------------------------------
// escaped_frame_receiver_test: self-checking bench for the frame deframer
// Feeds escaped line bytes (noise, broken frames, well-formed frames with
// random content) through the stream input. A local deframer follows every
// accepted byte and queues the payload and verdict beats it should cause.
// The output monitor checks each beat in order against that queue.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_test;
   import erx_pkg::*;

   localparam int FRAME_MAX    = FRAME_MAX_DEFAULT;
   localparam int HOLD_AT      = 250;  // accepted bytes before the long output stall
   localparam int HOLD_CYCLES  = 150;
   localparam int STEADY_FROM  = 420;  // window of accepted bytes with no idling
   localparam int STEADY_TO    = 540;
   localparam int SETTLE       = 10;   // cycles to let the pipeline empty

   typedef enum {
      FLAW_NONE, FLAW_CHECKSUM, FLAW_SHORT, FLAW_RETURN,
      FLAW_COMMAND, FLAW_ESCAPE, FLAW_ABORT, FLAW_OVERSIZE
   } frame_flaw_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [7:0] payload_byte, [10:8] verdict
   logic        rsp_tuser;            // [0] item_kind
   logic        rsp_tlast;            // frame_last
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = 8'h00;   // [7:0] expected_command

   escaped_frame_receiver #(.MAX_FRAME(FRAME_MAX)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // line bytes waiting to be offered, and beats the deframer still owes
   logic [7:0] line_bytes[$];
   res_type    beats_due[$];
   int         bytes_queued = 0;
   int         lines_taken  = 0;
   int         errors       = 0;
   logic [7:0] cmd_setting  = 8'h00;  // command byte the generator puts in frames

   // local deframer state
   logic [7:0] cmd_expect;
   logic       framing;
   logic       esc_armed;
   logic [8:0] unesc_pos;
   logic [7:0] check_acc;
   logic [7:0] tail_byte;
   logic       tail_held;
   logic [7:0] declared_len;
   logic       ret_seen_bad;
   logic       cmd_seen_bad;
   logic [1:0] sticky_err;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Deframer prediction
   // ---------------------------------------------------------------------
   function automatic void owe_beat(input logic kind, input logic [7:0] data,
                                    input logic [2:0] verdict);
      res_type r;
      r.item_kind    = kind;
      r.payload_byte = data;
      r.verdict      = verdict;
      r.frame_last   = kind;
      beats_due.push_back(r);
   endfunction

   function automatic void open_frame();
      framing      = 1'b1;
      esc_armed    = 1'b0;
      unesc_pos    = 9'd1;
      check_acc    = 8'h00;
      tail_byte    = 8'h00;
      tail_held    = 1'b0;
      declared_len = 8'h00;
      ret_seen_bad = 1'b0;
      cmd_seen_bad = 1'b0;
      sticky_err   = ERR_NONE;
   endfunction

   function automatic void hunt();
      open_frame();
      framing   = 1'b0;
      unesc_pos = 9'd0;
   endfunction

   // take one unescaped byte; the byte it displaces is released if it is payload
   function automatic void take_unescaped(input logic [7:0] b);
      int held_at;
      if (unesc_pos > FRAME_MAX - 2) begin
         sticky_err = ERR_OVERFLOW;
         return;
      end
      if (unesc_pos == POS_RETURN && b != 8'h00) ret_seen_bad = 1'b1;
      if (unesc_pos == POS_COMMAND && b != cmd_expect) cmd_seen_bad = 1'b1;
      if (unesc_pos == POS_LENGTH) declared_len = b;
      if (tail_held) begin
         held_at   = int'(unesc_pos) - 1;
         check_acc = check_acc ^ tail_byte;
         if (held_at >= POS_PAYLOAD && held_at < POS_PAYLOAD + int'(declared_len))
            owe_beat(ITEM_PAYLOAD, tail_byte, VERDICT_GOOD);
      end
      tail_byte = b;
      tail_held = 1'b1;
      unesc_pos = unesc_pos + 9'd1;
   endfunction

   function automatic logic [2:0] closing_verdict();
      if (esc_armed || sticky_err == ERR_ESCAPE) return VERDICT_ESCAPE;
      if (sticky_err == ERR_OVERFLOW) return VERDICT_OVERFLOW;
      if (!tail_held || int'(unesc_pos) - 1 < POS_PAYLOAD + int'(declared_len))
         return VERDICT_SHORT;
      if (check_acc != tail_byte) return VERDICT_CHECKSUM;
      if (ret_seen_bad) return VERDICT_RETURN;
      if (cmd_seen_bad) return VERDICT_COMMAND;
      return VERDICT_GOOD;
   endfunction

   function automatic void deframe_step(input logic [7:0] b);
      logic [2:0] v;
      if (b == BYTE_HEADER) begin
         if (framing) owe_beat(ITEM_VERDICT, 8'h00, VERDICT_ABORTED);
         open_frame();
      end else if (framing) begin
         if (b == BYTE_TRAILER) begin
            v = closing_verdict();
            hunt();
            owe_beat(ITEM_VERDICT, 8'h00, v);
         end else if (sticky_err == ERR_NONE) begin
            if (esc_armed) begin
               esc_armed = 1'b0;
               case (b)
                  ESC_CODE_FF: take_unescaped(BYTE_HEADER);
                  ESC_CODE_FE: take_unescaped(BYTE_TRAILER);
                  ESC_CODE_FD: take_unescaped(BYTE_ESCAPE);
                  default:     sticky_err = ERR_ESCAPE;
               endcase
            end else if (b == BYTE_ESCAPE) begin
               esc_armed = 1'b1;
            end else begin
               take_unescaped(b);
            end
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Line byte driver: offer the next queued byte, idle at random outside
   // the steady window, and follow every accepted beat in the deframer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            deframe_step(req_tdata);
            lines_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (line_bytes.size() != 0 &&
                ((lines_taken >= STEADY_FROM && lines_taken < STEADY_TO) ||
                 $urandom_range(99) >= 19)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= line_bytes.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: check each beat against the oldest owed beat, and
   // pace tready, with one long hold-off so the block backs up into its input
   // ---------------------------------------------------------------------
   int   stall_left = 0;
   logic stall_done = 1'b0;

   always @(posedge clock) begin
      res_type want;
      res_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.item_kind    = rsp_tuser;
            got.payload_byte = rsp_tdata[7:0];
            got.verdict      = rsp_tdata[10:8];
            got.frame_last   = rsp_tlast;
            if (beats_due.size() == 0) begin
               $display("%0t: unexpected rsp beat kind=%0d byte=%02h verdict=%0d last=%0d",
                        $time, got.item_kind, got.payload_byte, got.verdict,
                        got.frame_last);
               errors++;
            end else begin
               want = beats_due.pop_front();
               if (got.item_kind !== want.item_kind ||
                   got.payload_byte !== want.payload_byte ||
                   got.verdict !== want.verdict ||
                   got.frame_last !== want.frame_last) begin
                  $display("%0t: rsp mismatch expected kind=%0d byte=%02h verdict=%0d last=%0d",
                           $time, want.item_kind, want.payload_byte, want.verdict,
                           want.frame_last);
                  $display("%0t:              actual kind=%0d byte=%02h verdict=%0d last=%0d",
                           $time, got.item_kind, got.payload_byte, got.verdict,
                           got.frame_last);
                  errors++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!stall_done && lines_taken >= HOLD_AT) begin
            // hold off while the sender keeps going, so the result queue fills
            stall_done <= 1'b1;
            stall_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (lines_taken >= STEADY_FROM && lines_taken < STEADY_TO) ||
                          $urandom_range(99) >= 19;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus building
   // ---------------------------------------------------------------------
   function automatic void push_line(input logic [7:0] b);
      line_bytes.push_back(b);
      bytes_queued++;
   endfunction

   // escape the three reserved codes on the line
   function automatic void push_stuffed(input logic [7:0] b);
      case (b)
         BYTE_HEADER:  begin push_line(BYTE_ESCAPE); push_line(ESC_CODE_FF); end
         BYTE_TRAILER: begin push_line(BYTE_ESCAPE); push_line(ESC_CODE_FE); end
         BYTE_ESCAPE:  begin push_line(BYTE_ESCAPE); push_line(ESC_CODE_FD); end
         default:      push_line(b);
      endcase
   endfunction

   // lean toward the reserved codes so escapes show up often
   function automatic logic [7:0] content_byte();
      if ($urandom_range(3) != 0) return 8'($urandom);
      case ($urandom_range(3))
         0:       return BYTE_HEADER;
         1:       return BYTE_TRAILER;
         2:       return BYTE_ESCAPE;
         default: return 8'($urandom_range(2));
      endcase
   endfunction

   // build one frame: header, eight filler bytes, return, command, length,
   // payload, optional trailing bytes, XOR checksum, trailer
   task automatic queue_frame(input frame_flaw_type flaw, input int plen);
      logic [7:0] body[$];
      logic [7:0] sum;
      int         fill;
      int         k;
      fill = plen;
      if (flaw == FLAW_SHORT) fill = $urandom_range(0, plen - 1);
      if (flaw == FLAW_OVERSIZE) fill = 250;
      repeat (8) body.push_back(content_byte());
      body.push_back(flaw == FLAW_RETURN ? 8'($urandom_range(1, 255)) : 8'h00);
      body.push_back(flaw == FLAW_COMMAND ? cmd_setting ^ 8'($urandom_range(1, 255))
                                          : cmd_setting);
      body.push_back(8'(plen));
      repeat (fill) body.push_back(content_byte());
      if (flaw == FLAW_NONE && $urandom_range(3) == 0)
         repeat ($urandom_range(1, 2)) body.push_back(content_byte());
      sum = 8'h00;
      foreach (body[i]) sum ^= body[i];
      if (flaw == FLAW_CHECKSUM) sum ^= 8'($urandom_range(1, 255));
      body.push_back(sum);
      k = $urandom_range(0, body.size() - 1);
      push_line(BYTE_HEADER);
      foreach (body[i]) begin
         if (i == k && flaw == FLAW_ESCAPE) begin
            push_line(BYTE_ESCAPE);
            push_line(8'($urandom_range(3, 254)));
         end
         if (i == k && flaw == FLAW_ABORT) push_line(BYTE_HEADER);
         push_stuffed(body[i]);
      end
      push_line(BYTE_TRAILER);
   endtask

   // mostly clean frames, the rest broken in one way, with line noise between
   task automatic queue_random_frames(input int budget);
      int             start;
      int             r;
      int             plen;
      frame_flaw_type flaw;
      start = bytes_queued;
      while (bytes_queued - start < budget) begin
         r = $urandom_range(99);
         if (r < 55)      flaw = FLAW_NONE;
         else if (r < 63) flaw = FLAW_CHECKSUM;
         else if (r < 71) flaw = FLAW_SHORT;
         else if (r < 78) flaw = FLAW_RETURN;
         else if (r < 85) flaw = FLAW_COMMAND;
         else if (r < 92) flaw = FLAW_ESCAPE;
         else             flaw = FLAW_ABORT;
         plen = ($urandom_range(4) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
         if (flaw == FLAW_SHORT && plen == 0) plen = 1;
         if ($urandom_range(5) == 0)
            repeat ($urandom_range(1, 3)) push_line(8'($urandom_range(0, 254)));
         queue_frame(flaw, plen);
      end
   endtask

   // wait until every byte is taken and every owed beat has come out
   task automatic drain();
      while (line_bytes.size() != 0 || req_tvalid || beats_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_command(input logic [7:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      cmd_expect  = value;
      cmd_setting = value;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      hunt();
      cmd_expect = 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // noise while hunting, including a stray trailer and escape
      push_line(8'h00);
      push_line(BYTE_TRAILER);
      push_line(BYTE_ESCAPE);
      push_line(8'h80);
      // header straight into trailer: no checksum byte at all
      push_line(BYTE_HEADER);
      push_line(BYTE_TRAILER);
      // second header aborts the open frame
      push_line(BYTE_HEADER);
      push_line(BYTE_HEADER);
      push_line(BYTE_TRAILER);
      // escape followed by an illegal code
      push_line(BYTE_HEADER);
      push_line(BYTE_ESCAPE);
      push_line(8'h05);
      push_line(BYTE_TRAILER);
      // trailer while an escape is still pending
      push_line(BYTE_HEADER);
      push_line(BYTE_ESCAPE);
      push_line(BYTE_TRAILER);
      // clean frame with a single payload byte
      queue_frame(FLAW_NONE, 1);
      drain();

      write_command(8'hFF);
      queue_random_frames(70);
      drain();

      write_command(8'h00);
      queue_random_frames(70);
      drain();

      // one frame runs past the size limit
      write_command(8'($urandom));
      queue_frame(FLAW_OVERSIZE, 255);
      queue_random_frames(50);
      drain();

      write_command(8'($urandom));
      queue_random_frames(60);
      drain();

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ----- escaped_frame_receiver.f -----
hdl/erx_pkg.sv
hdl/erx_deframer.sv
hdl/erx_out_queue.sv
hdl/escaped_frame_receiver.sv
dv/escaped_frame_receiver_test.sv
